FILE: hw/rtl/brc_pkg.sv
// Shared types, widths, register indexes and reset values for the
// cascaded balance controller. No dependencies.
package brc_pkg;

    localparam int GAIN_W    = 32;
    localparam int ANGLE_W   = 17;
    localparam int RATE_W    = 16;
    localparam int COUNT_W   = 16;
    localparam int HEAD_W    = 8;
    localparam int DRIVE_W   = 32;
    localparam int CFG_W     = 32;
    localparam int REG_IDX_W = 3;
    localparam int SPEED_W   = 32;
    localparam int INTEG_W   = 23;
    localparam int NUM_W     = 34;
    localparam int PROD_W    = 64;
    localparam int TERM_W    = 36;

    localparam int UP_SHIFT    = 24;
    localparam int SPD_SHIFT   = 30;
    localparam int RATE_SHIFT  = 8;
    localparam int INTEG_SHIFT = 6;

    localparam int DIV_STEP_DEF = 8;

    localparam logic [REG_IDX_W-1:0] REG_BALANCE_KP     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BALANCE_KD     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VELOCITY_KP    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VELOCITY_KI    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TURN_KP        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TURN_KD        = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BALANCE_OFFSET = 3'd6;

    localparam logic signed [GAIN_W-1:0]  BALANCE_KP_RST     = 32'sd45875200;
    localparam logic signed [GAIN_W-1:0]  BALANCE_KD_RST     = 32'sd78643;
    localparam logic signed [GAIN_W-1:0]  VELOCITY_KP_RST    = 32'sd13107200;
    localparam logic signed [GAIN_W-1:0]  VELOCITY_KI_RST    = 32'sd0;
    localparam logic signed [GAIN_W-1:0]  TURN_KP_RST        = 32'sd0;
    localparam logic signed [GAIN_W-1:0]  TURN_KD_RST        = 32'sd0;
    localparam logic signed [ANGLE_W-1:0] BALANCE_OFFSET_RST = 17'sd0;

    localparam logic signed [ANGLE_W-1:0] TILT_LIMIT     = 17'sd15360;
    localparam logic signed [ANGLE_W-1:0] TILT_LIMIT_NEG = -17'sd15360;
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT     = 23'sd2560000;
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT_NEG = -23'sd2560000;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_RATE,
        SH_INTEG
    } t_pshift;

    typedef enum logic [1:0] {
        TERM_UP,
        TERM_SPD,
        TERM_TURN
    } t_term;

    typedef struct packed {
        logic    mul_en;
        logic    acc_en;
        logic    acc_load;
        logic    acc_neg;
        t_pshift shift;
        logic    term_wr;
        t_term   term_sel;
    } t_mac_ctl;

endpackage

FILE: hw/rtl/balance_robot_cascade_pid.sv
// Top level of the cascaded balance controller: config registers, sequencer,
// filter state and output register. Depends on brc_pkg, brc_div5, brc_mac.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+-------------------------------
//  cfg     | in        | i_cfg_we                      | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_stall       | pitch, yaw, rate, counts, heading
//  out     | out       | o_out_valid / i_out_stall     | drive_a, drive_b, tilt_cutoff
//
// A normal tick runs from accepting the beat through the divide, integral
// and product states to loading the output register: the divide-by-five
// filter runs P_DIV_STEP bits a cycle, then six products share one multiplier.
// A tilt cutoff beat goes straight to the output state. o_in_stall is high while
// a tick is in work; the output register lets a new beat in while a result waits.
// Synchronous active-low reset restores gains and clears the speed state.
module balance_robot_cascade_pid
    import brc_pkg::*;
#(
    parameter int P_DIV_STEP = DIV_STEP_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [REG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [ANGLE_W-1:0] i_pitch_angle,
    input  logic signed [ANGLE_W-1:0] i_yaw_angle,
    input  logic signed [RATE_W-1:0]  i_pitch_rate,
    input  logic signed [COUNT_W-1:0] i_left_count,
    input  logic signed [COUNT_W-1:0] i_right_count,
    input  logic [HEAD_W-1:0]         i_target_heading,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_drive_a,
    output logic signed [DRIVE_W-1:0] o_drive_b,
    output logic                      o_tilt_cutoff
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_INT,
        S_MAC,
        S_SUM
    } t_state;

    localparam int ISUM_W = INTEG_W + 4;

    t_state r_state;
    logic [2:0] r_step;

    logic signed [GAIN_W-1:0]  r_balance_kp;
    logic signed [GAIN_W-1:0]  r_balance_kd;
    logic signed [GAIN_W-1:0]  r_velocity_kp;
    logic signed [GAIN_W-1:0]  r_velocity_ki;
    logic signed [GAIN_W-1:0]  r_turn_kp;
    logic signed [GAIN_W-1:0]  r_turn_kd;
    logic signed [ANGLE_W-1:0] r_balance_offset;

    logic signed [SPEED_W-1:0] r_speed_f;
    logic signed [INTEG_W-1:0] r_speed_i;

    logic signed [ANGLE_W-1:0] r_pitch;
    logic signed [ANGLE_W-1:0] r_yaw;
    logic signed [RATE_W-1:0]  r_rate;
    logic [HEAD_W-1:0]         r_head;
    logic                      r_cut;

    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive_a;
    logic signed [DRIVE_W-1:0] r_drive_b;
    logic                      r_tilt;

    logic                      w_accept;
    logic                      w_tilt;
    logic signed [COUNT_W:0]   w_count_sum;
    logic signed [30:0]        w_sum_sh;
    logic signed [NUM_W-1:0]   w_num;
    logic                      w_div_done;
    logic signed [SPEED_W-1:0] w_quot;
    logic signed [SPEED_W-1:0] w_sf_bias;
    logic signed [SPEED_W-1:0] w_sf_q;
    logic signed [ISUM_W-1:0]  w_isum;
    logic signed [INTEG_W-1:0] w_integ_new;
    logic signed [ANGLE_W:0]   w_pitch_err;
    logic signed [ANGLE_W:0]   w_head_err;
    t_mac_ctl                  w_ctl;
    logic signed [GAIN_W-1:0]  w_a;
    logic signed [GAIN_W-1:0]  w_b;
    logic signed [TERM_W-1:0]  w_upright;
    logic signed [TERM_W-1:0]  w_speed;
    logic signed [TERM_W-1:0]  w_turn;
    logic signed [TERM_W-1:0]  w_sum_a;
    logic signed [TERM_W-1:0]  w_sum_b;

    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [TERM_W-1:0] v
    );
        logic [TERM_W-DRIVE_W:0] top;
        top = v[TERM_W-1:DRIVE_W-1];
        if (top == '0 || top == '1) begin
            return v[DRIVE_W-1:0];
        end
        return v[TERM_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_balance_kp     <= BALANCE_KP_RST;
            r_balance_kd     <= BALANCE_KD_RST;
            r_velocity_kp    <= VELOCITY_KP_RST;
            r_velocity_ki    <= VELOCITY_KI_RST;
            r_turn_kp        <= TURN_KP_RST;
            r_turn_kd        <= TURN_KD_RST;
            r_balance_offset <= BALANCE_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BALANCE_KP:     r_balance_kp     <= i_cfg_data;
                REG_BALANCE_KD:     r_balance_kd     <= i_cfg_data;
                REG_VELOCITY_KP:    r_velocity_kp    <= i_cfg_data;
                REG_VELOCITY_KI:    r_velocity_ki    <= i_cfg_data;
                REG_TURN_KP:        r_turn_kp        <= i_cfg_data;
                REG_TURN_KD:        r_turn_kd        <= i_cfg_data;
                REG_BALANCE_OFFSET: r_balance_offset <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_tilt   = (i_pitch_angle > TILT_LIMIT) || (i_pitch_angle < TILT_LIMIT_NEG);

    // filter numerator: 4*s + (left + right) * 2^14
    assign w_count_sum = {i_left_count[COUNT_W-1], i_left_count}
                       + {i_right_count[COUNT_W-1], i_right_count};
    assign w_sum_sh    = {w_count_sum, 14'd0};
    assign w_num       = {r_speed_f, 2'b00} + NUM_W'(w_sum_sh);

    brc_div5 #(
        .P_DIV_STEP (P_DIV_STEP)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && !w_tilt),
        .i_num   (w_num),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // integral += trunc0(s / 64), clamped
    assign w_sf_bias = r_speed_f + {26'd0, {6{r_speed_f[SPEED_W-1]}}};
    assign w_sf_q    = w_sf_bias >>> 6;
    assign w_isum    = ISUM_W'(r_speed_i) + ISUM_W'(w_sf_q);

    always_comb begin
        if (w_isum > ISUM_W'(INTEG_LIMIT)) begin
            w_integ_new = INTEG_LIMIT;
        end else if (w_isum < ISUM_W'(INTEG_LIMIT_NEG)) begin
            w_integ_new = INTEG_LIMIT_NEG;
        end else begin
            w_integ_new = w_isum[INTEG_W-1:0];
        end
    end

    assign w_pitch_err = {r_pitch[ANGLE_W-1], r_pitch}
                       - {r_balance_offset[ANGLE_W-1], r_balance_offset};
    assign w_head_err  = $signed({2'b00, r_head, 8'd0}) - {r_yaw[ANGLE_W-1], r_yaw};

    // product k issues at step k, accumulates at step k+1; terms land after
    // each pair is summed
    always_comb begin
        w_ctl = '0;
        w_a   = '0;
        w_b   = '0;
        if (r_state == S_MAC) begin
            unique case (r_step)
                3'd0: begin
                    w_ctl.mul_en = 1'b1;
                    w_a = r_balance_kp;
                    w_b = GAIN_W'(w_pitch_err);
                end
                3'd1: begin
                    w_ctl.mul_en   = 1'b1;
                    w_ctl.acc_en   = 1'b1;
                    w_ctl.acc_load = 1'b1;
                    w_a = r_balance_kd;
                    w_b = GAIN_W'(r_rate);
                end
                3'd2: begin
                    w_ctl.mul_en = 1'b1;
                    w_ctl.acc_en = 1'b1;
                    w_ctl.shift  = SH_RATE;
                    w_a = r_velocity_kp;
                    w_b = r_speed_f;
                end
                3'd3: begin
                    w_ctl.mul_en   = 1'b1;
                    w_ctl.acc_en   = 1'b1;
                    w_ctl.acc_load = 1'b1;
                    w_ctl.term_wr  = 1'b1;
                    w_ctl.term_sel = TERM_UP;
                    w_a = r_velocity_ki;
                    w_b = GAIN_W'(r_speed_i);
                end
                3'd4: begin
                    w_ctl.mul_en = 1'b1;
                    w_ctl.acc_en = 1'b1;
                    w_ctl.shift  = SH_INTEG;
                    w_a = r_turn_kp;
                    w_b = GAIN_W'(w_head_err);
                end
                3'd5: begin
                    w_ctl.mul_en   = 1'b1;
                    w_ctl.acc_en   = 1'b1;
                    w_ctl.acc_load = 1'b1;
                    w_ctl.acc_neg  = 1'b1;
                    w_ctl.term_wr  = 1'b1;
                    w_ctl.term_sel = TERM_SPD;
                    w_a = r_turn_kd;
                    w_b = GAIN_W'(r_yaw);
                end
                3'd6: begin
                    w_ctl.acc_en  = 1'b1;
                    w_ctl.acc_neg = 1'b1;
                end
                default: begin
                    w_ctl.term_wr  = 1'b1;
                    w_ctl.term_sel = TERM_TURN;
                end
            endcase
        end
    end

    brc_mac u_mac (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_a       (w_a),
        .i_b       (w_b),
        .o_upright (w_upright),
        .o_speed   (w_speed),
        .o_turn    (w_turn)
    );

    assign w_sum_a = w_upright + w_speed + w_turn;
    assign w_sum_b = w_upright + w_speed - w_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_speed_f   <= '0;
            r_speed_i   <= '0;
            r_cut       <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pitch <= i_pitch_angle;
                        r_yaw   <= i_yaw_angle;
                        r_rate  <= i_pitch_rate;
                        r_head  <= i_target_heading;
                        r_cut   <= w_tilt;
                        if (w_tilt) begin
                            r_speed_f <= '0;
                            r_speed_i <= '0;
                            r_state   <= S_SUM;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_speed_f <= w_quot;
                        r_state   <= S_INT;
                    end
                end
                S_INT: begin
                    r_speed_i <= w_integ_new;
                    r_step    <= '0;
                    r_state   <= S_MAC;
                end
                S_MAC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd7) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_tilt      <= r_cut;
                        r_drive_a   <= r_cut ? '0 : sat_drive(w_sum_a);
                        r_drive_b   <= r_cut ? '0 : sat_drive(w_sum_b);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_drive_a     = r_drive_a;
    assign o_drive_b     = r_drive_b;
    assign o_tilt_cutoff = r_tilt;

    a_cut_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tilt_cutoff |-> (o_drive_a == '0) && (o_drive_b == '0))
        else $error("tilt cutoff beat with nonzero drive");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after accepting a beat");

    a_integ_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_speed_i <= INTEG_LIMIT) && (r_speed_i >= INTEG_LIMIT_NEG))
        else $error("speed integral out of clamp range");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

endmodule

FILE: hw/rtl/brc_div5.sv
// Digit-serial restoring divider by five for the speed low-pass filter.
// Quotient truncates toward zero. Depends on brc_pkg.
module brc_div5
    import brc_pkg::*;
#(
    parameter int P_DIV_STEP = DIV_STEP_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [NUM_W-1:0]   i_num,
    output logic                      o_done,
    output logic signed [SPEED_W-1:0] o_quot
);

    localparam int MAG_W   = NUM_W;
    localparam int N_STEPS = (MAG_W + P_DIV_STEP - 1) / P_DIV_STEP;
    localparam int SR_W    = N_STEPS * P_DIV_STEP;
    localparam int CNT_W   = $clog2(N_STEPS + 1);

    logic [SR_W-1:0]  r_sr;
    logic [SR_W-1:0]  n_sr;
    logic [2:0]       r_rem;
    logic [2:0]       n_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_neg;
    logic             r_done;
    logic [MAG_W-1:0] w_mag;
    logic [SPEED_W-1:0] w_q;

    assign w_mag = i_num[NUM_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);

    always_comb begin
        logic [3:0] t;
        n_sr  = r_sr;
        n_rem = r_rem;
        for (int k = 0; k < P_DIV_STEP; k++) begin
            t    = {n_rem, n_sr[SR_W-1]};
            n_sr = {n_sr[SR_W-2:0], 1'b0};
            if (t >= 4'd5) begin
                t       = t - 4'd5;
                n_sr[0] = 1'b1;
            end
            n_rem = t[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_STEPS);
                r_sr   <= SR_W'(w_mag);
                r_rem  <= '0;
                r_neg  <= i_num[NUM_W-1];
            end else if (r_busy) begin
                r_sr  <= n_sr;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_q    = r_sr[SPEED_W-1:0];
    assign o_quot = r_neg ? -w_q : w_q;
    assign o_done = r_done;

endmodule

FILE: hw/rtl/brc_mac.sv
// Shared 32x32 multiplier, product accumulator and truncating scaler that
// builds the upright, speed and heading terms. Depends on brc_pkg.
module brc_mac
    import brc_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [GAIN_W-1:0] i_a,
    input  logic signed [GAIN_W-1:0] i_b,
    output logic signed [TERM_W-1:0] o_upright,
    output logic signed [TERM_W-1:0] o_speed,
    output logic signed [TERM_W-1:0] o_turn
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] w_sh;
    logic signed [PROD_W-1:0] w_add;
    logic signed [PROD_W-1:0] w_bias;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [TERM_W-1:0] w_term;
    logic signed [TERM_W-1:0] r_upright;
    logic signed [TERM_W-1:0] r_speed;
    logic signed [TERM_W-1:0] r_turn;

    always_comb begin
        case (i_ctl.shift)
            SH_RATE:  w_sh = r_prod <<< RATE_SHIFT;
            SH_INTEG: w_sh = r_prod <<< INTEG_SHIFT;
            default:  w_sh = r_prod;
        endcase
        w_add = i_ctl.acc_neg ? -w_sh : w_sh;
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    always_comb begin
        if (i_ctl.term_sel == TERM_SPD) begin
            w_bias = r_acc[PROD_W-1] ? ((PROD_W'(1) <<< SPD_SHIFT) - PROD_W'(1)) : '0;
            w_rnd  = r_acc + w_bias;
            w_term = TERM_W'(w_rnd >>> SPD_SHIFT);
        end else begin
            w_bias = r_acc[PROD_W-1] ? ((PROD_W'(1) <<< UP_SHIFT) - PROD_W'(1)) : '0;
            w_rnd  = r_acc + w_bias;
            w_term = TERM_W'(w_rnd >>> UP_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
        if (i_ctl.acc_en) begin
            r_acc <= (i_ctl.acc_load ? '0 : r_acc) + w_add;
        end
        if (i_ctl.term_wr) begin
            case (i_ctl.term_sel)
                TERM_UP:  r_upright <= w_term;
                TERM_SPD: r_speed   <= w_term;
                default:  r_turn    <= w_term;
            endcase
        end
    end

    assign o_upright = r_upright;
    assign o_speed   = r_speed;
    assign o_turn    = r_turn;

endmodule

FILE: test/tb_balance_robot_cascade_pid.sv
`timescale 1ns / 1ps
// Self-checking testbench for balance_robot_cascade_pid: drives random and directed
// control ticks through the valid/stall channels and checks the motor drives against an
// in-bench model of the cascaded loops. Depends on brc_pkg and the controller RTL.
module tb_balance_robot_cascade_pid;
    import brc_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     TAIL_CYCLES = 40;
    localparam int     HOLD_CYCLES = 300;
    localparam int     FLOOD_BEATS = 60;
    localparam longint TILT_Q8     = 15360;
    localparam longint INTEG_CAP   = 2560000;
    localparam longint UP_SCALE    = 64'sd1 << 24;
    localparam longint SPD_SCALE   = 64'sd1 << 30;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        logic signed [RATE_W-1:0]  rate;
        logic signed [COUNT_W-1:0] left_count;
        logic signed [COUNT_W-1:0] right_count;
        logic [HEAD_W-1:0]         heading;
    } tick_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_a;
        logic signed [DRIVE_W-1:0] drive_b;
        logic                      tilt_cutoff;
    } drive_t;

    typedef enum logic [1:0] {
        STALL_OFF,
        STALL_COIN,
        STALL_HEAVY,
        STALL_BURSTY
    } stall_style_t;

    class drive_scoreboard;
        longint bal_kp, bal_kd, vel_kp, vel_ki, trn_kp, trn_kd, bal_off;
        longint spd_filt, spd_integ;
        drive_t expected_q[$];
        int     errors;

        function new();
            bal_kp    = 45875200;
            bal_kd    = 78643;
            vel_kp    = 13107200;
            vel_ki    = 0;
            trn_kp    = 0;
            trn_kd    = 0;
            bal_off   = 0;
            spd_filt  = 0;
            spd_integ = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_BALANCE_KP:     bal_kp  = longint'($signed(data));
                REG_BALANCE_KD:     bal_kd  = longint'($signed(data));
                REG_VELOCITY_KP:    vel_kp  = longint'($signed(data));
                REG_VELOCITY_KI:    vel_ki  = longint'($signed(data));
                REG_TURN_KP:        trn_kp  = longint'($signed(data));
                REG_TURN_KD:        trn_kd  = longint'($signed(data));
                REG_BALANCE_OFFSET: bal_off = longint'($signed(data[ANGLE_W-1:0]));
                default: ;
            endcase
        endfunction

        function logic signed [DRIVE_W-1:0] clip32(longint v);
            if (v > 64'sd2147483647)
                return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return v[DRIVE_W-1:0];
        endfunction

        function void note_tick(tick_t t);
            longint pitch, yaw, rate, cnt_sum, head, upright, speed, turn;
            drive_t d;
            pitch   = longint'($signed(t.pitch));
            yaw     = longint'($signed(t.yaw));
            rate    = longint'($signed(t.rate));
            cnt_sum = longint'($signed(t.left_count)) + longint'($signed(t.right_count));
            head    = longint'(t.heading);
            if (pitch > TILT_Q8 || pitch < -TILT_Q8) begin
                spd_filt      = 0;
                spd_integ     = 0;
                d.drive_a     = '0;
                d.drive_b     = '0;
                d.tilt_cutoff = 1'b1;
            end else begin
                upright = (bal_kp * (pitch - bal_off) + bal_kd * rate * 256) / UP_SCALE;
                // 0.8 / 0.2 low-pass on the encoder sum, Q14
                spd_filt  = (4 * spd_filt + cnt_sum * 16384) / 5;
                spd_integ = spd_integ + spd_filt / 64;
                if (spd_integ > INTEG_CAP)
                    spd_integ = INTEG_CAP;
                if (spd_integ < -INTEG_CAP)
                    spd_integ = -INTEG_CAP;
                speed = (vel_kp * spd_filt + vel_ki * spd_integ * 64) / SPD_SCALE;
                turn  = (-(trn_kp * (head * 256 - yaw)) - trn_kd * yaw) / UP_SCALE;
                d.drive_a     = clip32(upright + speed + turn);
                d.drive_b     = clip32(upright + speed - turn);
                d.tilt_cutoff = 1'b0;
            end
            expected_q.push_back(d);
        endfunction

        function void check_drive(drive_t got);
            drive_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: drive_a %0d drive_b %0d",
                         $time, got.drive_a, got.drive_b);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.drive_a !== want.drive_a) begin
                $display("%0t: drive_a expected %0d actual %0d",
                         $time, want.drive_a, got.drive_a);
                errors++;
            end
            if (got.drive_b !== want.drive_b) begin
                $display("%0t: drive_b expected %0d actual %0d",
                         $time, want.drive_b, got.drive_b);
                errors++;
            end
            if (got.tilt_cutoff !== want.tilt_cutoff) begin
                $display("%0t: tilt_cutoff expected %0b actual %0b",
                         $time, want.tilt_cutoff, got.tilt_cutoff);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_we         = 1'b0;
    logic [REG_IDX_W-1:0]      i_cfg_index      = '0;
    logic [CFG_W-1:0]          i_cfg_data       = '0;
    logic                      i_in_valid       = 1'b0;
    logic                      o_in_stall;
    logic signed [ANGLE_W-1:0] i_pitch_angle    = '0;
    logic signed [ANGLE_W-1:0] i_yaw_angle      = '0;
    logic signed [RATE_W-1:0]  i_pitch_rate     = '0;
    logic signed [COUNT_W-1:0] i_left_count     = '0;
    logic signed [COUNT_W-1:0] i_right_count    = '0;
    logic [HEAD_W-1:0]         i_target_heading = '0;
    logic                      o_out_valid;
    logic                      i_out_stall      = 1'b0;
    logic signed [DRIVE_W-1:0] o_drive_a;
    logic signed [DRIVE_W-1:0] o_drive_b;
    logic                      o_tilt_cutoff;

    drive_scoreboard sb = new();

    bit           hold_req    = 1'b0;
    bit           hold_ack    = 1'b0;
    int           hold_left   = 0;
    int           mode_left   = 0;
    stall_style_t stall_style = STALL_OFF;
    bit           drift_up    = 1'b1;
    int           cycles      = 0;

    balance_robot_cascade_pid uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pitch_angle    (i_pitch_angle),
        .i_yaw_angle      (i_yaw_angle),
        .i_pitch_rate     (i_pitch_rate),
        .i_left_count     (i_left_count),
        .i_right_count    (i_right_count),
        .i_target_heading (i_target_heading),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive_a        (o_drive_a),
        .o_drive_b        (o_drive_b),
        .o_tilt_cutoff    (o_tilt_cutoff)
    );

    always #5 i_clk = ~i_clk;

    // receiver: changing stall styles, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (mode_left == 0) begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
            mode_left   <= $urandom_range(20, 200);
            i_out_stall <= 1'b0;
        end else begin
            mode_left <= mode_left - 1;
            case (stall_style)
                STALL_OFF:    i_out_stall <= 1'b0;
                STALL_COIN:   i_out_stall <= $urandom_range(0, 1);
                STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 9) < 8);
                STALL_BURSTY: i_out_stall <= ((mode_left % 7) < 3);
                default:      i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_drive({o_drive_a, o_drive_b, o_tilt_cutoff});
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL balance_robot_cascade_pid");
        $finish;
    end

    task automatic send_tick(input tick_t t);
        i_in_valid       <= 1'b1;
        i_pitch_angle    <= t.pitch;
        i_yaw_angle      <= t.yaw;
        i_pitch_rate     <= t.rate;
        i_left_count     <= t.left_count;
        i_right_count    <= t.right_count;
        i_target_heading <= t.heading;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_tick(t);
    endtask

    task automatic send_fields(input int pitch, yaw, rate, lcount, rcount, head);
        tick_t t;
        t.pitch       = pitch;
        t.yaw         = yaw;
        t.rate        = rate;
        t.left_count  = lcount;
        t.right_count = rcount;
        t.heading     = head;
        send_tick(t);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_regs(input logic [CFG_W-1:0] bkp, bkd, vkp, vki, tkp, tkd, off);
        cfg_write(REG_BALANCE_KP, bkp);
        cfg_write(REG_BALANCE_KD, bkd);
        cfg_write(REG_VELOCITY_KP, vkp);
        cfg_write(REG_VELOCITY_KI, vki);
        cfg_write(REG_TURN_KP, tkp);
        cfg_write(REG_TURN_KD, tkd);
        cfg_write(REG_BALANCE_OFFSET, off);
        cfg_write(REG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit flood);
        tick_t t;
        int    burst_left;
        int    gap;
        int    mag_l;
        int    mag_r;
        burst_left = $urandom_range(1, 30);
        if (flood)
            hold_req <= ~hold_req;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0, 1:    t.pitch = $urandom;
                2, 3:    t.pitch = ($urandom_range(0, 1) ? 15360 : -15360)
                                   + $urandom_range(0, 2) - 1;
                default: t.pitch = $urandom_range(0, 30720) - 15360;
            endcase
            t.yaw     = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : $urandom_range(0, 92160) - 46080;
            t.rate    = $urandom;
            t.heading = $urandom;
            if ($urandom_range(0, 39) == 0)
                drift_up = ~drift_up;
            case ($urandom_range(0, 4))
                0, 1: begin
                    t.left_count  = $urandom;
                    t.right_count = $urandom;
                end
                2, 3: begin
                    // sustained drive one way to push the integral into its clamp
                    mag_l = $urandom_range(4000, 32767);
                    mag_r = $urandom_range(4000, 32767);
                    t.left_count  = drift_up ? mag_l : -mag_l;
                    t.right_count = drift_up ? mag_r : -mag_r;
                end
                default: begin
                    t.left_count  = $urandom_range(0, 100) - 50;
                    t.right_count = $urandom_range(0, 100) - 50;
                end
            endcase
            send_tick(t);
            if (!flood || n >= FLOOD_BEATS) begin
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains, field extremes and the tilt boundary
        send_fields(0, 0, 0, 0, 0, 0);
        send_fields(15360, 46080, 32767, 32767, 32767, 255);
        send_fields(-15360, -46080, -32768, -32768, -32768, 0);
        send_fields(15361, 100, 1000, 500, 500, 10);
        send_fields(100, 0, 0, 1000, 1000, 0);
        send_fields(-15361, -100, -1000, -500, -500, 20);
        send_fields(100, 0, 0, 1000, 1000, 0);
        send_fields(100, 0, 0, 1000, 1000, 0);
        send_fields(46080, 46080, 0, 0, 0, 0);
        send_fields(-46080, -46080, 0, 0, 0, 0);
        send_fields(65535, 65535, 32767, 1, 1, 255);
        send_fields(-65536, -65536, -32768, -1, -1, 128);
        send_fields(15359, 0, 0, 30000, 30000, 90);
        wait_drained();

        // extreme gains, out-of-range offset (upper data bits ignored): drives saturate
        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000);
        repeat (4) send_fields(15360, -46080, 32767, 32767, 32767, 0);
        repeat (3) send_fields(-15360, 46080, -32768, -32768, -32768, 255);
        wait_drained();

        load_regs(32'd45875200, 32'd78643, 32'd13107200, 32'd65536,
                  32'd1966080, 32'd327680, 32'd256);
        run_random(260, 1'b0);

        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF);
        run_random(220, 1'b1);

        load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
        run_random(220, 1'b0);

        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_random(250, 1'b0);

        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_random(250, 1'b0);

        load_regs('0, '0, '0, '0, '0, '0, $urandom);
        run_random(150, 1'b0);

        load_regs(-32'sd45875200, -32'sd78643, -32'sd13107200, -32'sd131072,
                  -32'sd1966080, -32'sd327680, $urandom_range(0, 92160) - 46080);
        run_random(350, 1'b1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS balance_robot_cascade_pid");
        else
            $display("FAIL balance_robot_cascade_pid");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/brc_pkg.sv
hw/rtl/brc_div5.sv
hw/rtl/brc_mac.sv
hw/rtl/balance_robot_cascade_pid.sv
test/tb_balance_robot_cascade_pid.sv
